### rtl/core/tdms_pkg.sv
// Package for the table-driven mode supervisor.
// Holds sizes, mode and command codes, row types and the default row table.
// No dependencies.
package tdms_pkg;

    localparam int NUM_ROWS     = 13;
    localparam int NUM_MODES    = 5;
    localparam int DEFAULT_ROWS = 13;
    localparam int ROW_AW       = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int MODE_W       = 3;
    localparam int MASK_W       = 5;
    localparam int NUM_W        = 4;
    localparam int CMD_W        = 3;
    localparam int STATUS_W     = 2;

    localparam logic [MASK_W-1:0] MODE_MASK = MASK_W'((1 << NUM_MODES) - 1);

    typedef logic [ROW_AW-1:0] row_idx_t;
    typedef logic [MODE_W-1:0] mode_t;

    localparam mode_t M_SAFE  = 3'd0;
    localparam mode_t M_READY = 3'd1;
    localparam mode_t M_SLEEP = 3'd2;
    localparam mode_t M_PAYA  = 3'd3;
    localparam mode_t M_PAYB  = 3'd4;

    localparam logic [MASK_W-1:0] TRIG_ANY   = 5'b11111;
    localparam logic [MASK_W-1:0] TRIG_SAFE  = 5'b00001;
    localparam logic [MASK_W-1:0] TRIG_READY = 5'b00010;
    localparam logic [MASK_W-1:0] TRIG_SLEEP = 5'b00100;
    localparam logic [MASK_W-1:0] TRIG_PAYA  = 5'b01000;
    localparam logic [MASK_W-1:0] TRIG_PAYB  = 5'b10000;

    typedef enum logic [CMD_W-1:0] {
        CMD_EVENT   = 3'd0,
        CMD_ENABLE  = 3'd1,
        CMD_DISABLE = 3'd2,
        CMD_ALLOW   = 3'd3,
        CMD_FORBID  = 3'd4,
        CMD_READ    = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_ROW  = 2'd1,
        ST_REFUSED  = 2'd2
    } status_t;

    typedef struct packed {
        logic              en;
        logic [MASK_W-1:0] mask;
    } row_t;

    typedef struct packed {
        logic     rd_en;
        row_idx_t rd_addr;
        logic     wr_en;
        row_idx_t wr_addr;
        row_t     wr_data;
    } row_req_t;

    function automatic logic [MASK_W-1:0] default_mask(input row_idx_t i);
        logic [MASK_W-1:0] m;
        case (int'(i))
            0:       m = TRIG_READY;
            1:       m = TRIG_READY;
            2:       m = TRIG_SLEEP;
            3:       m = TRIG_ANY;
            4:       m = TRIG_ANY;
            5:       m = TRIG_SAFE;
            6:       m = TRIG_ANY;
            7:       m = TRIG_ANY;
            8:       m = TRIG_READY;
            9:       m = TRIG_READY;
            10:      m = TRIG_PAYA;
            11:      m = TRIG_READY;
            12:      m = TRIG_PAYB;
            default: m = '0;
        endcase
        return m & MODE_MASK;
    endfunction

    function automatic mode_t default_target(input row_idx_t i);
        mode_t t;
        case (int'(i))
            5:       t = M_READY;
            9:       t = M_PAYA;
            10:      t = M_READY;
            11:      t = M_PAYB;
            12:      t = M_READY;
            default: t = M_SAFE;
        endcase
        return t;
    endfunction

    function automatic row_t default_row(input row_idx_t i);
        row_t r;
        r.en   = (int'(i) < DEFAULT_ROWS);
        r.mask = default_mask(i);
        return r;
    endfunction

endpackage

### rtl/core/tdms_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tdms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/tdms_row_store.sv
// Transition row store: RAM of enable and mask per row, plus per-row written bits
// so that rows never written read as the default table. Uses tdms_pkg, tdms_ram.
module tdms_row_store
    import tdms_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  row_req_t req,
    output row_t     rd_row
);

    logic [NUM_ROWS-1:0] written_reg;
    logic                rd_written_reg;
    row_t                rd_dflt_reg;
    row_t                ram_q;

    tdms_ram #(
        .WIDTH ($bits(row_t)),
        .DEPTH (NUM_ROWS)
    ) u_ram (
        .clk     (clk),
        .rd_en   (req.rd_en),
        .rd_addr (req.rd_addr),
        .rd_data (ram_q),
        .wr_en   (req.wr_en),
        .wr_addr (req.wr_addr),
        .wr_data (req.wr_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (req.wr_en)
        begin
            written_reg[req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_written_reg <= written_reg[req.rd_addr];
            rd_dflt_reg    <= default_row(req.rd_addr);
        end
    end

    assign rd_row = rd_written_reg ? ram_q : rd_dflt_reg;

endmodule

### rtl/core/table_driven_mode_supervisor_top.sv
// Table-driven mode supervisor, top level. Uses tdms_pkg, tdms_row_store.
// A transfer reads the row; the execute step applies the command and registers the result.
// The next command is taken only after the read-modify-write of the row RAM is done.
// A held result does not block the next command transfer; only a second result stalls.
// Reset: mode is sleep; all rows read as the default table at once, no clearing pass.
module table_driven_mode_supervisor_top
    import tdms_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  logic [CMD_W-1:0]    command,
    input  logic [NUM_W-1:0]    transition_number,
    input  logic [MODE_W-1:0]   mode_select,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic [MODE_W-1:0]   current_mode,
    output logic [STATUS_W-1:0] status,
    output logic                row_enabled,
    output logic [MASK_W-1:0]   row_trigger_mask
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t              state_reg, state_next;
    logic [CMD_W-1:0]    cmd_reg;
    logic                row_ok_reg;
    row_idx_t            idx_reg;
    logic [MODE_W-1:0]   sel_reg;
    mode_t               mode_reg, mode_next;
    logic                rsp_valid_reg, rsp_valid_next;
    status_t             status_reg, status_next;
    logic                row_en_reg, row_en_next;
    logic [MASK_W-1:0]   row_mask_reg, row_mask_next;

    logic                accept;
    logic                finish;
    logic                num_ok;
    row_req_t            req;
    row_t                rd_row;
    row_t                new_row;
    logic [7:0]          mask8;
    logic [7:0]          sel_bit;
    logic                sel_ok;

    assign cmd_ready = (state_reg == S_IDLE);
    assign accept    = cmd_valid && cmd_ready;
    assign num_ok    = (transition_number != '0) && (int'(transition_number) <= NUM_ROWS);
    assign finish    = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp_ready);

    assign mask8   = 8'(rd_row.mask);
    assign sel_bit = 8'd1 << sel_reg;
    assign sel_ok  = int'(sel_reg) < NUM_MODES;

    tdms_row_store u_rows (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .rd_row (rd_row)
    );

    always_comb
    begin
        new_row       = rd_row;
        mode_next     = mode_reg;
        status_next   = ST_OK;
        row_en_next   = 1'b0;
        row_mask_next = '0;
        if (!row_ok_reg)
        begin
            if (cmd_reg <= CMD_FORBID)
            begin
                status_next = ST_BAD_ROW;
            end
        end
        else
        begin
            unique case (cmd_t'(cmd_reg))
                CMD_EVENT:
                begin
                    if (rd_row.en && mask8[mode_reg])
                    begin
                        mode_next = default_target(idx_reg);
                    end
                    else
                    begin
                        status_next = ST_REFUSED;
                    end
                end
                CMD_ENABLE:  new_row.en = 1'b1;
                CMD_DISABLE: new_row.en = 1'b0;
                CMD_ALLOW:
                begin
                    if (sel_ok)
                    begin
                        new_row.mask = (rd_row.mask | sel_bit[MASK_W-1:0]) & MODE_MASK;
                    end
                end
                CMD_FORBID:
                begin
                    if (sel_ok)
                    begin
                        new_row.mask = rd_row.mask & ~sel_bit[MASK_W-1:0] & MODE_MASK;
                    end
                end
                default: ;
            endcase
            row_en_next   = new_row.en;
            row_mask_next = new_row.mask;
        end
    end

    always_comb
    begin
        req.rd_en   = accept;
        req.rd_addr = ROW_AW'(transition_number - 4'd1);
        req.wr_en   = finish && row_ok_reg
                      && (cmd_reg >= CMD_ENABLE) && (cmd_reg <= CMD_FORBID);
        req.wr_addr = idx_reg;
        req.wr_data = new_row;
    end

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (finish)
                begin
                    state_next     = S_IDLE;
                    rsp_valid_next = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= M_SLEEP;
            rsp_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            row_en_reg    <= 1'b0;
            row_mask_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (finish)
            begin
                mode_reg     <= mode_next;
                status_reg   <= status_next;
                row_en_reg   <= row_en_next;
                row_mask_reg <= row_mask_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= command;
            row_ok_reg <= num_ok;
            idx_reg    <= ROW_AW'(transition_number - 4'd1);
            sel_reg    <= mode_select;
        end
    end

    assign rsp_valid        = rsp_valid_reg;
    assign current_mode     = mode_reg;
    assign status           = status_reg;
    assign row_enabled      = row_en_reg;
    assign row_trigger_mask = row_mask_reg;

`ifndef ASSERT_OFF
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !cmd_ready)
        else $error("command transfer while previous command in flight");

    a_bad_row_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_BAD_ROW) |-> !row_enabled && (row_trigger_mask == '0))
        else $error("bad row status with nonzero row fields");

    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(current_mode) < NUM_MODES)
        else $error("mode out of range");

    a_rsp_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == S_EXEC))
        else $error("result raised outside execute step");
`endif

endmodule
